/* hdl/ldm_pkg.sv */
// shared types, constants and helpers for the lens distortion map
package ldm_pkg;

  localparam int MAX_ITERATIONS = 50;
  localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);
  localparam int NUM_REGS       = 7;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 48;

  localparam logic signed [63:0] WORK_LIMIT = 64'sh1FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q32_MAX    = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] Q32_MIN    = -64'sh0000_0000_8000_0000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K3   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DECENTER_P1 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DECENTER_P2 = 3'd6;

  // actions
  localparam logic ACT_UNDISTORT = 1'b0;
  localparam logic ACT_DISTORT   = 1'b1;

  // product sequence of one distortion evaluation
  typedef enum logic [3:0] {
    OP_XX, OP_YY, OP_XY, OP_R4, OP_K2, OP_K3,
    OP_XDR, OP_P1X, OP_P2X, OP_YDR, OP_P1Y, OP_P2Y
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT, ST_EVAL, ST_PUSH
  } state_e;

  typedef struct packed {
    logic start;
    logic sh44;
  } mul_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > Q32_MAX) r = Q32_MAX;
    if (v < Q32_MIN) r = Q32_MIN;
    return r[31:0];
  endfunction

  function automatic logic signed [63:0] clamp_work(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > WORK_LIMIT) r = WORK_LIMIT;
    if (v < -WORK_LIMIT) r = -WORK_LIMIT;
    return r;
  endfunction

endpackage

/* hdl/lens_distortion_map_core.sv */
// top level: config registers, product sequencer and result register
// undistort runs one pass of the 12-product sequence, distort runs one pass
// per iteration, up to 50 iterations
// throughput: one point at a time, set by the single shared 64x64 product
// unit that runs four 32x32 partial products per term
// reset: asynchronous active low, clears control state and all coefficients
module lens_distortion_map_core import ldm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write word
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input word
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  action_i,
  input  logic signed [31:0]    coord_x_i,
  input  logic signed [31:0]    coord_y_i,
  // result word
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [31:0]    result_x_o,
  output logic signed [31:0]    result_y_o,
  output logic                  ok_o
);

  // coefficient registers
  logic signed [31:0] prin_x_q, prin_y_q;
  logic signed [47:0] k1_q, k2_q, k3_q, p1_q, p2_q;

  state_e state_q, state_d;
  op_e    op_q;

  // item context
  logic               action_q;
  logic signed [31:0] cx_q, cy_q;   // input point
  logic signed [31:0] tx_q, ty_q;   // point the distortion is evaluated at
  logic signed [31:0] px_q, py_q;   // previous iterate
  logic               have_prev_q;
  logic [ITER_W-1:0]  iter_q;

  // partial results of the evaluation
  logic signed [63:0] xx_q, yy_q, xy_q, r4_q, dr_q, ox_q, oy_q;

  // pending result and output register
  logic signed [31:0] fin_x_q, fin_y_q, res_x_q, res_y_q;
  logic               fin_ok_q, res_ok_q, out_valid_q;

  // shared product unit
  mul_req_t           mreq;
  logic signed [63:0] ma, mb, mres;
  logic               mdone;

  ldm_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .a_i    (ma),
    .b_i    (mb),
    .done_o (mdone),
    .res_o  (mres)
  );

  logic               in_acc, out_take, cfg_acc;
  logic signed [63:0] tx_w, ty_w, rr;
  logic signed [31:0] und_x, und_y, nx, ny, dist_x, dist_y;
  logic signed [63:0] ex, ey;
  logic               conv, last_iter;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;

  assign tx_w = 64'(tx_q);
  assign ty_w = 64'(ty_q);
  assign rr   = xx_q + yy_q;

  // operand select per step of the product sequence
  always_comb begin
    ma        = tx_w;
    mb        = tx_w;
    mreq.sh44 = 1'b0;
    case (op_q)
      OP_XX:  begin ma = tx_w; mb = tx_w; end
      OP_YY:  begin ma = ty_w; mb = ty_w; end
      OP_XY:  begin ma = tx_w; mb = ty_w; end
      OP_R4:  begin ma = rr; mb = rr; end
      OP_K2:  begin ma = 64'(k2_q); mb = rr; end
      OP_K3:  begin ma = 64'(k3_q); mb = r4_q; end
      OP_XDR: begin ma = tx_w; mb = dr_q; mreq.sh44 = 1'b1; end
      OP_P1X: begin ma = 64'(p1_q); mb = rr + (xx_q <<< 1); mreq.sh44 = 1'b1; end
      OP_P2X: begin ma = 64'(p2_q); mb = xy_q <<< 1; mreq.sh44 = 1'b1; end
      OP_YDR: begin ma = ty_w; mb = dr_q; mreq.sh44 = 1'b1; end
      OP_P1Y: begin ma = 64'(p1_q); mb = xy_q <<< 1; mreq.sh44 = 1'b1; end
      OP_P2Y: begin ma = 64'(p2_q); mb = rr + (yy_q <<< 1); mreq.sh44 = 1'b1; end
      default: begin ma = tx_w; mb = tx_w; end
    endcase
    mreq.start = (state_q == ST_ISSUE);
  end

  // end of one evaluation: undistort result or next distort iterate
  always_comb begin
    und_x     = sat32(64'(cx_q) + ox_q);
    und_y     = sat32(64'(cy_q) + oy_q);
    nx        = sat32(64'(cx_q) - ox_q);
    ny        = sat32(64'(cy_q) - oy_q);
    ex        = 64'(nx) - 64'(px_q);
    ey        = 64'(ny) - 64'(py_q);
    conv      = have_prev_q && ex <= 64'sd1 && ex >= -64'sd1
                && ey <= 64'sd1 && ey >= -64'sd1;
    last_iter = (iter_q == ITER_W'(MAX_ITERATIONS - 1));
    dist_x    = sat32(64'(nx) + 64'(prin_x_q));
    dist_y    = sat32(64'(ny) + 64'(prin_y_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_ISSUE;
      ST_ISSUE: state_d = ST_WAIT;
      ST_WAIT: begin
        if (mdone) state_d = (op_q == OP_P2Y) ? ST_EVAL : ST_ISSUE;
      end
      ST_EVAL: begin
        if (action_q == ACT_UNDISTORT || conv || last_iter) state_d = ST_PUSH;
        else state_d = ST_ISSUE;
      end
      ST_PUSH:  if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prin_x_q <= '0;
      prin_y_q <= '0;
      k1_q     <= '0;
      k2_q     <= '0;
      k3_q     <= '0;
      p1_q     <= '0;
      p2_q     <= '0;
    end else if (cfg_acc) begin
      case (cfg_index_i)
        REG_PRINCIPAL_X: prin_x_q <= cfg_data_i[31:0];
        REG_PRINCIPAL_Y: prin_y_q <= cfg_data_i[31:0];
        REG_RADIAL_K1:   k1_q     <= cfg_data_i;
        REG_RADIAL_K2:   k2_q     <= cfg_data_i;
        REG_RADIAL_K3:   k3_q     <= cfg_data_i;
        REG_DECENTER_P1: p1_q     <= cfg_data_i;
        REG_DECENTER_P2: p2_q     <= cfg_data_i;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= OP_XX;
      iter_q      <= '0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // a new word loads the output register, otherwise a taken word leaves
      if (state_q == ST_PUSH && (!out_valid_q || !out_stall_i)) out_valid_q <= 1'b1;
      else if (out_take) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            op_q        <= OP_XX;
            iter_q      <= '0;
            have_prev_q <= 1'b0;
          end
        end
        ST_WAIT: begin
          if (mdone && op_q != OP_P2Y) op_q <= op_e'(op_q + 4'd1);
        end
        ST_EVAL: begin
          op_q        <= OP_XX;
          have_prev_q <= 1'b1;
          iter_q      <= iter_q + ITER_W'(1);
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          action_q <= action_i;
          cx_q     <= coord_x_i;
          cy_q     <= coord_y_i;
          // undistort works on the offset point, distort starts at the input
          if (action_i == ACT_UNDISTORT) begin
            tx_q <= sat32(64'(coord_x_i) - 64'(prin_x_q));
            ty_q <= sat32(64'(coord_y_i) - 64'(prin_y_q));
          end else begin
            tx_q <= coord_x_i;
            ty_q <= coord_y_i;
          end
        end
      end
      ST_WAIT: begin
        if (mdone) begin
          case (op_q)
            OP_XX:  xx_q <= mres;
            OP_YY:  yy_q <= mres;
            OP_XY:  xy_q <= mres;
            OP_R4:  r4_q <= mres;
            OP_K2:  dr_q <= 64'(k1_q) + mres;
            OP_K3:  dr_q <= clamp_work(dr_q + mres);
            OP_XDR: ox_q <= mres;
            OP_P1X: ox_q <= ox_q + mres;
            OP_P2X: ox_q <= ox_q + mres;
            OP_YDR: oy_q <= mres;
            OP_P1Y: oy_q <= oy_q + mres;
            OP_P2Y: oy_q <= oy_q + mres;
            default: ;
          endcase
        end
      end
      ST_EVAL: begin
        if (action_q == ACT_UNDISTORT) begin
          fin_x_q  <= und_x;
          fin_y_q  <= und_y;
          fin_ok_q <= 1'b1;
        end else begin
          fin_x_q  <= dist_x;
          fin_y_q  <= dist_y;
          fin_ok_q <= conv;
          tx_q     <= nx;
          ty_q     <= ny;
          px_q     <= nx;
          py_q     <= ny;
        end
      end
      ST_PUSH: begin
        if (!out_valid_q || !out_stall_i) begin
          res_x_q  <= fin_x_q;
          res_y_q  <= fin_y_q;
          res_ok_q <= fin_ok_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign result_x_o  = res_x_q;
  assign result_y_o  = res_y_q;
  assign ok_o        = res_ok_q;

endmodule

/* hdl/ldm_mul.sv */
// shared multi-cycle signed multiply, shift, truncate and saturate unit
module ldm_mul import ldm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mul_req_t            req_i,
  input  logic signed [63:0]  a_i,
  input  logic signed [63:0]  b_i,
  output logic                done_o,
  output logic signed [63:0]  res_o
);

  logic [63:0]  ua_q, ub_q;
  logic         neg_q, sh44_q, busy_q, done_q;
  logic [2:0]   step_q;
  logic [127:0] prod_q;
  logic signed [63:0] res_q;

  logic [31:0]  opa, opb;
  logic [63:0]  pp;
  logic [127:0] pp_sh, q_full;
  logic [63:0]  q_sat;

  always_comb begin
    opa    = step_q[1] ? ua_q[63:32] : ua_q[31:0];
    opb    = step_q[0] ? ub_q[63:32] : ub_q[31:0];
    pp     = 64'(opa) * 64'(opb);
    // weight 2^(32*(i+j))
    case (step_q[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    q_full = sh44_q ? (prod_q >> 44) : (prod_q >> 20);
    q_sat  = (q_full > 128'(WORK_LIMIT)) ? 64'(WORK_LIMIT) : q_full[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (req_i.start) begin
          busy_q <= 1'b1;
          step_q <= 3'd0;
        end
      end else if (step_q == 3'd4) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        step_q <= step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && req_i.start) begin
      ua_q   <= a_i[63] ? 64'(-a_i) : 64'(a_i);
      ub_q   <= b_i[63] ? 64'(-b_i) : 64'(b_i);
      neg_q  <= a_i[63] ^ b_i[63];
      sh44_q <= req_i.sh44;
      prod_q <= '0;
    end else if (busy_q && step_q != 3'd4) begin
      prod_q <= prod_q + pp_sh;
    end else if (busy_q) begin
      res_q  <= neg_q ? -$signed(q_sat) : $signed(q_sat);
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* hdl/ldm_checker.sv */
// port-level checks for the lens distortion map core and their binding
module ldm_checker import ldm_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] result_x_o,
  input logic signed [31:0] result_y_o,
  input logic               ok_o
);

  // busy right after an item is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("core took another word while computing");

  // a new result never shows right after an item is taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !$rose(out_valid_o))
    else $error("result appeared without computation");

  // a result only appears at the end of a computation
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while idle");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_x_o)
      && $stable(result_y_o) && $stable(ok_o)))
    else $error("stalled result word changed");

endmodule

bind lens_distortion_map_core ldm_checker u_ldm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .result_x_o  (result_x_o),
  .result_y_o  (result_y_o),
  .ok_o        (ok_o)
);

/* tb/sv/lens_distortion_map_checker.sv */
// checker for the lens distortion map: models the block and compares every result word
`timescale 1ns / 100ps
module lens_distortion_map_checker import ldm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  action_i,
  input  logic signed [31:0]    coord_x_i,
  input  logic signed [31:0]    coord_y_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic signed [31:0]    result_x_i,
  input  logic signed [31:0]    result_y_i,
  input  logic                  ok_i,
  output int                    errors_o,
  output int                    pending_o,
  output int                    checked_o,
  output int                    noconv_o
);

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               ok;
  } mapped_point_t;

  logic signed [63:0] coef [NUM_REGS];
  mapped_point_t      mapped_q [$];

  // exact product, shifted toward zero, clipped to the working range
  function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                        input logic signed [63:0] b,
                                                        input int sh);
    logic          neg;
    logic [63:0]   ua;
    logic [63:0]   ub;
    logic [127:0]  q;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? 64'(-a) : 64'(a);
    ub  = (b < 0) ? 64'(-b) : 64'(b);
    q   = ({64'd0, ua} * {64'd0, ub}) >> sh;
    if (q > 128'(WORK_LIMIT)) q = 128'(WORK_LIMIT);
    return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic logic signed [63:0] clip_q32(input logic signed [63:0] v);
    if (v > Q32_MAX) return Q32_MAX;
    if (v < Q32_MIN) return Q32_MIN;
    return v;
  endfunction

  task automatic lens_offset(input logic signed [63:0] x, input logic signed [63:0] y,
                             output logic signed [63:0] dx, output logic signed [63:0] dy);
    logic signed [63:0] xx, yy, xy, rr, r4, dr;
    xx = scaled_product(x, x, 20);
    yy = scaled_product(y, y, 20);
    xy = scaled_product(x, y, 20);
    rr = xx + yy;
    r4 = scaled_product(rr, rr, 20);
    dr = coef[REG_RADIAL_K1] + scaled_product(coef[REG_RADIAL_K2], rr, 20)
       + scaled_product(coef[REG_RADIAL_K3], r4, 20);
    if (dr > WORK_LIMIT) dr = WORK_LIMIT;
    if (dr < -WORK_LIMIT) dr = -WORK_LIMIT;
    dx = scaled_product(x, dr, 44) + scaled_product(coef[REG_DECENTER_P1], rr + 2 * xx, 44)
       + scaled_product(coef[REG_DECENTER_P2], 2 * xy, 44);
    dy = scaled_product(y, dr, 44) + scaled_product(coef[REG_DECENTER_P1], 2 * xy, 44)
       + scaled_product(coef[REG_DECENTER_P2], rr + 2 * yy, 44);
  endtask

  task automatic map_point(input logic act, input logic signed [31:0] cx,
                           input logic signed [31:0] cy, output mapped_point_t res);
    logic signed [63:0] dx, dy, tx, ty, px, py, ex, ey;
    logic               have_prev;
    tx = 64'(cx);
    ty = 64'(cy);
    px = '0;
    py = '0;
    have_prev = 1'b0;
    res.ok = 1'b1;
    if (act == ACT_UNDISTORT) begin
      lens_offset(clip_q32(cx - coef[REG_PRINCIPAL_X]), clip_q32(cy - coef[REG_PRINCIPAL_Y]),
                  dx, dy);
      res.x = 32'(clip_q32(cx + dx));
      res.y = 32'(clip_q32(cy + dy));
    end else begin
      res.ok = 1'b0;
      for (int i = 0; i < MAX_ITERATIONS; i++) begin
        lens_offset(tx, ty, dx, dy);
        tx = clip_q32(cx - dx);
        ty = clip_q32(cy - dy);
        ex = tx - px;
        ey = ty - py;
        if (have_prev && ex <= 1 && ex >= -1 && ey <= 1 && ey >= -1) begin
          res.ok = 1'b1;
          break;
        end
        px = tx;
        py = ty;
        have_prev = 1'b1;
      end
      res.x = 32'(clip_q32(tx + coef[REG_PRINCIPAL_X]));
      res.y = 32'(clip_q32(ty + coef[REG_PRINCIPAL_Y]));
    end
  endtask

  task automatic report_mismatch(input string field, input longint want, input longint got);
    $display("%0t: mismatch on %s, expected %0d, got %0d", $realtime, field, want, got);
    errors_o++;
  endtask

  assign pending_o = mapped_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    mapped_point_t want;
    if (!rst_ni) begin
      foreach (coef[i]) coef[i] = '0;
      mapped_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < NUM_REGS)
        coef[cfg_index_i] = (cfg_index_i < 2) ? 64'(signed'(cfg_data_i[31:0]))
                                              : 64'(signed'(cfg_data_i));
      if (in_valid_i && !in_stall_i) begin
        map_point(action_i, coord_x_i, coord_y_i, want);
        mapped_q.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (mapped_q.size() == 0) begin
          $display("%0t: result word with no point outstanding", $realtime);
          errors_o++;
        end else begin
          want = mapped_q.pop_front();
          checked_o++;
          if (!want.ok) noconv_o++;
          if (result_x_i !== want.x) report_mismatch("result_x", want.x, result_x_i);
          if (result_y_i !== want.y) report_mismatch("result_y", want.y, result_y_i);
          if (ok_i !== want.ok) report_mismatch("ok", want.ok, ok_i);
        end
      end
    end
  end

  initial begin
    errors_o  = 0;
    checked_o = 0;
    noconv_o  = 0;
  end

endmodule

/* tb/sv/lens_distortion_map_core_test.sv */
// stimulus, clocking and verdict for the lens distortion map core
`timescale 1ns / 100ps
module lens_distortion_map_core_test;
  import ldm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;   // beyond the register file
  localparam int IDLE_LIMIT = 30000;                    // watchdog limit on cycles without any word moving
  localparam int NUM_PHASES = 10;

  // coefficient setups, one per phase
  typedef enum int {SETUP_ZERO, SETUP_FIXED, SETUP_MAX, SETUP_MIN, SETUP_WILD, SETUP_MILD} setup_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  action = ACT_UNDISTORT;
  logic signed [31:0]    coord_x = '0;
  logic signed [31:0]    coord_y = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [31:0]    result_x;
  logic signed [31:0]    result_y;
  logic                  ok;

  int errors, pending, checked, noconv;
  int idle_cycles = 0;
  int stall_mode = 0;
  int sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lens_distortion_map_core DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .coord_x_i(coord_x), .coord_y_i(coord_y),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .result_x_o(result_x), .result_y_o(result_y), .ok_o(ok)
  );

  lens_distortion_map_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .action_i(action), .coord_x_i(coord_x), .coord_y_i(coord_y),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .result_x_i(result_x), .result_y_i(result_y), .ok_i(ok),
    .errors_o(errors), .pending_o(pending), .checked_o(checked), .noconv_o(noconv)
  );

  // receiver stall: switches now and then between never, light and heavy stalling
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  // watchdog: too long without any word moving on any channel
  always @(posedge clk) begin
    if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("watchdog expired with %0d points outstanding", pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // random value of the given width, sign extended
  function automatic logic signed [63:0] rand_signed(input int bits);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return $signed(raw) >>> (64 - bits);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // present one point and hold it until the block takes it; valid stays high
  task automatic send_point(input logic act, input logic signed [31:0] x,
                            input logic signed [31:0] y);
    @(negedge clk);
    in_valid <= 1'b1;
    action   <= act;
    coord_x  <= x;
    coord_y  <= y;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // drop valid and wait until every point has come back
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic setup_coefs(input setup_e kind);
    logic signed [63:0] v [NUM_REGS];
    case (kind)
      SETUP_ZERO: begin
        foreach (v[i]) v[i] = '0;
      end
      SETUP_FIXED: begin
        v[REG_PRINCIPAL_X] = -64'sd2097152;    // -2 mm, lets a top-edge x saturate
        v[REG_PRINCIPAL_Y] = 64'sd1572864;
        v[REG_RADIAL_K1]   = -64'sd17592186;   // about -1e-6 scaled
        v[REG_RADIAL_K2]   = 64'sd1 <<< 28;
        v[REG_RADIAL_K3]   = -(64'sd1 <<< 20);
        v[REG_DECENTER_P1] = 64'sd1 <<< 30;
        v[REG_DECENTER_P2] = -(64'sd1 <<< 31);
      end
      SETUP_MAX: begin
        v[REG_PRINCIPAL_X] = Q32_MAX;
        v[REG_PRINCIPAL_Y] = Q32_MAX;
        for (int i = 2; i < NUM_REGS; i++) v[i] = (64'sd1 <<< 47) - 1;
      end
      SETUP_MIN: begin
        v[REG_PRINCIPAL_X] = Q32_MIN;
        v[REG_PRINCIPAL_Y] = Q32_MIN;
        for (int i = 2; i < NUM_REGS; i++) v[i] = -(64'sd1 <<< 47);
      end
      SETUP_WILD: begin
        v[REG_PRINCIPAL_X] = rand_signed(32);
        v[REG_PRINCIPAL_Y] = rand_signed(32);
        for (int i = 2; i < NUM_REGS; i++) v[i] = rand_signed(48);
      end
      default: begin
        // small lens: converges in a handful of iterations
        v[REG_PRINCIPAL_X] = rand_signed(23);
        v[REG_PRINCIPAL_Y] = rand_signed(23);
        v[REG_RADIAL_K1]   = rand_signed(38);
        v[REG_RADIAL_K2]   = rand_signed(30);
        v[REG_RADIAL_K3]   = rand_signed(22);
        v[REG_DECENTER_P1] = rand_signed(34);
        v[REG_DECENTER_P2] = rand_signed(34);
      end
    endcase
    for (int i = 0; i < NUM_REGS; i++) write_reg(i[CFG_IDX_W-1:0], v[i][CFG_DATA_W-1:0]);
  endtask

  // modest and wide coordinates, plus wide_pct percent of any 32-bit value
  task automatic send_random_points(input int count, input int wide_pct);
    int burst;
    int r;
    logic signed [31:0] x, y;
    burst = $urandom_range(1, 12);
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < wide_pct) begin
        x = $urandom;
        y = $urandom;
      end else if (r < wide_pct + 20) begin
        x = rand_signed(29);
        y = rand_signed(29);
      end else begin
        x = rand_signed(26);
        y = rand_signed(26);
      end
      send_point(($urandom_range(0, 99) < 35) ? ACT_DISTORT : ACT_UNDISTORT, x, y);
      burst--;
      if (burst == 0) begin
        // gaps of random length land on any cycle of the block's work
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 40)) @(negedge clk);
        burst = $urandom_range(1, 12);
      end
    end
  endtask

  task automatic send_corners;
    send_point(ACT_UNDISTORT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(ACT_UNDISTORT, 32'sh8000_0000, 32'sh8000_0000);
    send_point(ACT_DISTORT,   32'sh7FFF_FFFF, 32'sh8000_0000);
    send_point(ACT_DISTORT,   32'sh8000_0000, 32'sh7FFF_FFFF);
    send_point(ACT_UNDISTORT, 32'sd0, 32'sd0);
    send_point(ACT_DISTORT,   32'sd0, 32'sd0);
  endtask

  initial begin
    setup_e kind;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      kind = (ph < 5) ? setup_e'(ph) : SETUP_MILD;
      setup_coefs(kind);
      case (kind)
        SETUP_ZERO: begin
          // a write past the last register must change nothing
          write_reg(REG_UNUSED, '1);
          send_corners();
          send_random_points(40, 10);
        end
        SETUP_FIXED: begin
          send_corners();
          // offset saturates against the principal point; points on and near it
          send_point(ACT_UNDISTORT, 32'sh7FFF_FFF0, -32'sd1048576);
          send_point(ACT_UNDISTORT, -32'sd2097152, 32'sd1572864);
          send_point(ACT_DISTORT,   -32'sd2097152, 32'sd1572864);
          send_point(ACT_UNDISTORT, 32'sd20971520, -32'sd15728640);
          send_point(ACT_DISTORT,   32'sd20971520, -32'sd15728640);
          send_point(ACT_DISTORT,   32'sh4000_0000, 32'sh4000_0000);
          send_random_points(150, 8);
          // hold off until the pipe is empty, then carry on
          drain();
          send_random_points(150, 8);
        end
        SETUP_MAX, SETUP_MIN, SETUP_WILD: begin
          // huge coefficients: saturation and non-converging distorts
          send_corners();
          send_random_points(12, 40);
        end
        default: begin
          send_random_points(290, 8);
        end
      endcase
      drain();
    end

    repeat (200) @(posedge clk);
    $display("sent %0d points over %0d coefficient setups, zero to full scale",
             sent, NUM_PHASES);
    $display("checked %0d results, %0d of them distorts that did not converge",
             checked, noconv);
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
hdl/ldm_pkg.sv
hdl/ldm_mul.sv
hdl/lens_distortion_map_core.sv
hdl/ldm_checker.sv
tb/sv/lens_distortion_map_checker.sv
tb/sv/lens_distortion_map_core_test.sv
